// ----- rtl/rfp_pkg.sv -----
package rfp_pkg;

  localparam int S_TDATA_W = 192;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 72;

  localparam logic [4:0] T_NONE        = 5'd0;
  localparam logic [4:0] T_ABS64       = 5'd1;
  localparam logic [4:0] T_ABS32       = 5'd2;
  localparam logic [4:0] T_ABS24       = 5'd3;
  localparam logic [4:0] T_PC32        = 5'd4;
  localparam logic [4:0] T_ABS32_NB    = 5'd5;
  localparam logic [4:0] T_ARM32       = 5'd6;
  localparam logic [4:0] T_ARM_PC26    = 5'd7;
  localparam logic [4:0] T_ARM_MOV32   = 5'd8;
  localparam logic [4:0] T_THUMB_MOV32 = 5'd9;
  localparam logic [4:0] T_THUMB_BR20  = 5'd10;
  localparam logic [4:0] T_THUMB_BLX23 = 5'd11;
  localparam logic [4:0] T_ADRP        = 5'd12;
  localparam logic [4:0] T_ADD_LO12    = 5'd13;
  localparam logic [4:0] T_LDST8_LO12  = 5'd14;
  localparam logic [4:0] T_LDST16_LO12 = 5'd15;
  localparam logic [4:0] T_LDST32_LO12 = 5'd16;
  localparam logic [4:0] T_LDST64_LO12 = 5'd17;
  localparam logic [4:0] T_LDST128_LO12 = 5'd18;
  localparam logic [4:0] T_JUMP26      = 5'd19;
  localparam logic [4:0] T_CALL26      = 5'd20;

  localparam logic [2:0] CNT_NONE  = 3'd0;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FOUR  = 3'd4;

  localparam logic       CFG_IMAGE_BASE = 1'b0;
  localparam logic       CFG_MSB_FIRST  = 1'b1;

  localparam logic [31:0] ADRP_MASK = 32'h60ffffe0;
  localparam logic [31:0] PAGE_MASK = ~32'hfff;

  typedef struct packed {
    logic [4:0]  rtype;
    logic [31:0] wlo;
    logic [31:0] whi;
    logic [31:0] addend;
    logic [31:0] sym_abs;
    logic [31:0] sym_rel;
    logic [31:0] place;
  } req_t;

  typedef struct packed {
    logic [4:0]  rtype;
    logic [31:0] wlo;
    logic [31:0] whi;
    logic [31:0] base;
    logic [31:0] opa;
    logic [31:0] opb;
  } s1_t;

  typedef struct packed {
    logic [4:0]  rtype;
    logic [31:0] wlo;
    logic [31:0] whi;
    logic [31:0] r;
  } s2_t;

  typedef struct packed {
    logic [31:0] nlo;
    logic [31:0] nhi;
    logic [2:0]  cnt;
    logic        hiw;
  } res_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [15:0] arm_mov_get(input logic [31:0] w);
    return {w[19:16], w[11:0]};
  endfunction

  function automatic logic [31:0] arm_mov_put(input logic [31:0] w, input logic [15:0] v);
    return {w[31:20], v[15:12], w[15:12], v[11:0]};
  endfunction

  function automatic logic [15:0] thumb_mov_get(input logic [31:0] w);
    return {w[3:0], w[10], w[30:28], w[23:16]};
  endfunction

  function automatic logic [31:0] thumb_mov_put(input logic [31:0] w, input logic [15:0] v);
    return {w[31], v[10:8], w[27:24], v[7:0], w[15:11], v[11], w[9:4], v[15:12]};
  endfunction

  // AArch64 field descriptors, indexed from ADD_LO12
  function automatic logic [31:0] a64_mask(input logic [2:0] idx);
    logic [31:0] m;
    unique case (idx)
      3'd0, 3'd1: m = 32'h003ffc00;
      3'd2:       m = 32'h001ffc00;
      3'd3:       m = 32'h000ffc00;
      3'd4:       m = 32'h0007fc00;
      3'd5:       m = 32'h0003fc00;
      default:    m = 32'h03ffffff;
    endcase
    return m;
  endfunction

  function automatic logic a64_pcrel(input logic [2:0] idx);
    return idx[2] & idx[1];
  endfunction

  function automatic logic [31:0] a64_value(input logic [2:0] idx, input logic [31:0] r);
    logic [31:0] v;
    unique case (idx)
      3'd0, 3'd1: v = {r[21:0], 10'd0};
      3'd2:       v = {r[22:1], 10'd0};
      3'd3:       v = {r[23:2], 10'd0};
      3'd4:       v = {r[24:3], 10'd0};
      3'd5:       v = {r[25:4], 10'd0};
      default:    v = {2'd0, r[31:2]};
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/relocation_field_patcher.sv -----
// Three register stages (operand decode, add, field insert); an accepted beat is
// registered through them in that order before it shows on m_tvalid.
// Throughput: one relocation per cycle while m_tready is high; a stalled output
// backs up stage by stage and then holds s_tready low.
// Reset (rst, synchronous): clears all stage valid bits; image_base and
// target_msb_first go to zero.
module relocation_field_patcher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // word_lo, word_hi, addend, sym_value_abs, sym_value_rel, place_rva
  input  logic [rfp_pkg::S_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic [rfp_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // new_word_lo, new_word_hi, lo_byte_count, hi_written, zero pad
  output logic [rfp_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [31:0]                    cfg_data
);
  import rfp_pkg::*;

  logic [31:0] image_base;
  logic        target_msb_first;
  req_t        req;
  s1_t         s1_data;
  s2_t         s2_data;
  res_t        res;
  logic        s1_valid;
  logic        s1_ready;
  logic        s2_valid;
  logic        s2_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base       <= '0;
      target_msb_first <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_BASE: image_base       <= cfg_data;
        CFG_MSB_FIRST:  target_msb_first <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign req.rtype   = s_tuser;
  assign req.wlo     = s_tdata[31:0];
  assign req.whi     = s_tdata[63:32];
  assign req.addend  = s_tdata[95:64];
  assign req.sym_abs = s_tdata[127:96];
  assign req.sym_rel = s_tdata[159:128];
  assign req.place   = s_tdata[191:160];

  rfp_operand u_operand (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (req),
    .image_base (image_base),
    .msb_first  (target_msb_first),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  rfp_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  rfp_patch u_patch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .in_ready   (s2_ready),
    .in_data    (s2_data),
    .msb_first  (target_msb_first),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (res)
  );

  assign m_tdata = {4'd0, res.hiw, res.cnt, res.nhi, res.nlo};

endmodule

// ----- rtl/rfp_operand.sv -----
module rfp_operand (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rfp_pkg::req_t in_data,
  input  logic [31:0]   image_base,
  input  logic          msb_first,
  output logic          out_valid,
  input  logic          out_ready,
  output rfp_pkg::s1_t  out_data
);
  import rfp_pkg::*;

  s1_t         s1_next;
  logic [31:0] implicit_val;
  logic [31:0] add_srel;
  logic [31:0] add_sabs;
  logic [31:0] place4;
  logic [31:0] base_place;
  logic [2:0]  a64_idx;
  logic [4:0]  a64_diff;

  assign in_ready   = !out_valid || out_ready;
  assign add_srel   = in_data.addend + in_data.sym_rel;
  assign add_sabs   = in_data.addend + in_data.sym_abs;
  assign place4     = in_data.place + 32'd4;
  assign base_place = image_base + in_data.place;
  assign a64_diff   = in_data.rtype - T_ADD_LO12;
  assign a64_idx    = a64_diff[2:0];

  always_comb begin
    logic [31:0] w;
    w = in_data.wlo;
    if (in_data.rtype == T_ABS24) begin
      implicit_val = msb_first ? {8'd0, w[7:0], w[15:8], w[23:16]} : {8'd0, w[23:0]};
    end else begin
      implicit_val = msb_first ? swap32(w) : w;
    end
  end

  always_comb begin
    s1_next.rtype = in_data.rtype;
    s1_next.wlo   = in_data.wlo;
    s1_next.whi   = in_data.whi;
    s1_next.base  = '0;
    s1_next.opa   = '0;
    s1_next.opb   = '0;
    unique case (in_data.rtype)
      T_ABS64, T_ABS32, T_ABS24, T_PC32, T_ABS32_NB, T_ARM32: begin
        s1_next.base = (in_data.addend != '0) ? in_data.addend : implicit_val;
        s1_next.opa  = (in_data.rtype == T_PC32 || in_data.rtype == T_ABS32_NB)
                       ? in_data.sym_rel : in_data.sym_abs;
        s1_next.opb  = (in_data.rtype == T_PC32) ? place4 : '0;
      end
      T_ARM_PC26: begin
        s1_next.base = {{6{in_data.wlo[23]}}, in_data.wlo[23:0], 2'b00};
        s1_next.opa  = add_srel;
        s1_next.opb  = in_data.place;
      end
      T_ARM_MOV32: begin
        s1_next.base = {arm_mov_get(in_data.whi), arm_mov_get(in_data.wlo)};
        s1_next.opa  = add_sabs;
      end
      T_THUMB_MOV32: begin
        s1_next.base = {thumb_mov_get(in_data.whi), thumb_mov_get(in_data.wlo)};
        s1_next.opa  = add_sabs;
      end
      T_THUMB_BR20: begin
        s1_next.base = {{11{in_data.wlo[10]}}, in_data.wlo[10], in_data.wlo[27],
                        in_data.wlo[29], in_data.wlo[5:0], in_data.wlo[26:16], 1'b0};
        s1_next.opa  = add_srel;
        s1_next.opb  = place4;
      end
      T_THUMB_BLX23: begin
        s1_next.base = {{9{in_data.wlo[10]}}, in_data.wlo[10:0], in_data.wlo[26:16], 1'b0};
        s1_next.opa  = add_srel;
        s1_next.opb  = place4;
      end
      T_ADRP: begin
        s1_next.opa = add_sabs & PAGE_MASK;
        s1_next.opb = base_place & PAGE_MASK;
      end
      T_ADD_LO12, T_LDST8_LO12, T_LDST16_LO12, T_LDST32_LO12, T_LDST64_LO12,
      T_LDST128_LO12, T_JUMP26, T_CALL26: begin
        s1_next.opa = add_sabs;
        s1_next.opb = a64_pcrel(a64_idx) ? base_place : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= s1_next;
    end
  end

endmodule

// ----- rtl/rfp_combine.sv -----
module rfp_combine (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rfp_pkg::s1_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rfp_pkg::s2_t out_data
);
  import rfp_pkg::*;

  s2_t s2_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    s2_next.rtype = in_data.rtype;
    s2_next.wlo   = in_data.wlo;
    s2_next.whi   = in_data.whi;
    s2_next.r     = in_data.base + in_data.opa - in_data.opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= s2_next;
    end
  end

endmodule

// ----- rtl/rfp_patch.sv -----
module rfp_patch (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rfp_pkg::s2_t  in_data,
  input  logic          msb_first,
  output logic          out_valid,
  input  logic          out_ready,
  output rfp_pkg::res_t out_data
);
  import rfp_pkg::*;

  res_t        res_next;
  logic [31:0] r;
  logic [31:0] w;
  logic [31:0] merge_mask;
  logic [31:0] merge_val;
  logic [31:0] merged;
  logic [4:0]  a64_diff;
  logic [2:0]  a64_idx;

  assign in_ready = !out_valid || out_ready;
  assign r        = in_data.r;
  assign w        = in_data.wlo;
  assign a64_diff = in_data.rtype - T_ADD_LO12;
  assign a64_idx  = a64_diff[2:0];

  always_comb begin
    if (in_data.rtype == T_ADRP) begin
      merge_mask = ADRP_MASK;
      merge_val  = {1'b0, r[13:12], 6'd0, r[31:14], 2'b00, r[11:9]};
    end else begin
      merge_mask = a64_mask(a64_idx);
      merge_val  = a64_value(a64_idx, r);
    end
    merged = (w & ~merge_mask) | (((w & merge_mask) + merge_val) & merge_mask);
  end

  always_comb begin
    res_next.nlo = w;
    res_next.nhi = in_data.whi;
    res_next.cnt = CNT_NONE;
    res_next.hiw = 1'b0;
    unique case (in_data.rtype)
      T_ABS24: begin
        res_next.nlo = msb_first ? {w[31:24], r[7:0], r[15:8], r[23:16]} : {w[31:24], r[23:0]};
        res_next.cnt = CNT_THREE;
      end
      T_ABS64, T_ABS32, T_PC32, T_ABS32_NB, T_ARM32: begin
        res_next.nlo = msb_first ? swap32(r) : r;
        res_next.cnt = CNT_FOUR;
      end
      T_ARM_PC26: begin
        res_next.nlo = {w[31:24], r[25:2]};
        res_next.cnt = CNT_THREE;
      end
      T_ARM_MOV32: begin
        res_next.nlo = arm_mov_put(w, r[15:0]);
        res_next.nhi = arm_mov_put(in_data.whi, r[31:16]);
        res_next.cnt = CNT_FOUR;
        res_next.hiw = 1'b1;
      end
      T_THUMB_MOV32: begin
        res_next.nlo = thumb_mov_put(w, r[15:0]);
        res_next.nhi = thumb_mov_put(in_data.whi, r[31:16]);
        res_next.cnt = CNT_FOUR;
        res_next.hiw = 1'b1;
      end
      T_THUMB_BR20: begin
        res_next.nlo = {w[31:30], r[18], w[28], r[19], r[11:1], w[15:11], r[20],
                        w[9:6], r[17:12]};
        res_next.cnt = CNT_FOUR;
      end
      T_THUMB_BLX23: begin
        res_next.nlo = {w[31:27], r[11:1], w[15:11], r[22:12]};
        res_next.cnt = CNT_FOUR;
      end
      T_ADRP, T_ADD_LO12, T_LDST8_LO12, T_LDST16_LO12, T_LDST32_LO12, T_LDST64_LO12,
      T_LDST128_LO12, T_JUMP26, T_CALL26: begin
        res_next.nlo = merged;
        res_next.cnt = CNT_FOUR;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_data <= res_next;
    end
  end

endmodule

// ----- rtl/rfp_checker.sv -----
module rfp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rfp_pkg::M_TDATA_W-1:0]  m_tdata
);
  import rfp_pkg::*;

  logic [2:0] cnt;
  logic       hiw;

  assign cnt = m_tdata[66:64];
  assign hiw = m_tdata[67];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_cnt_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cnt == CNT_NONE || cnt == CNT_THREE || cnt == CNT_FOUR))
    else $error("illegal byte count");

  a_hi_implies_four: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && hiw |-> cnt == CNT_FOUR)
    else $error("high word written without full low word");

  a_flow_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("accepted beat did not reach output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind relocation_field_patcher rfp_checker u_rfp_checker (.*);

// ----- tb/tb_relocation_field_patcher.sv -----
`timescale 1ns / 1ps

module tb_relocation_field_patcher;
  import rfp_pkg::*;

  localparam logic [4:0] T_UNKNOWN_LOW = 5'd21;
  localparam logic [4:0] T_UNKNOWN_TOP = 5'd31;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int NPHASE = 6;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] wlo;
    logic [31:0] whi;
    logic [31:0] addend;
    logic [31:0] sabs;
    logic [31:0] srel;
    logic [31:0] place;
  } reloc_t;

  typedef struct packed {
    logic [31:0] nlo;
    logic [31:0] nhi;
    logic [2:0]  cnt;
    logic        hiw;
  } patch_t;

  typedef struct {
    reloc_t q;
    bit     known;
    patch_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  // side info traveling with the input beat: hand-typed result for directed rows
  bit     typed_known = 1'b0;
  patch_t typed_want = '0;

  logic [31:0] cur_base = '0;
  logic        cur_be = 1'b0;

  patch_t expected_patches[$];
  vector_t directed[$];
  int relocs_sent = 0;
  int patches_checked = 0;
  int n_err = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  relocation_field_patcher dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] flip_bytes(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] merge_field(logic [31:0] w, logic [31:0] m, logic [31:0] v);
    return (w & ~m) | (((w & m) + v) & m);
  endfunction

  function automatic logic [15:0] arm_imm16(logic [31:0] w);
    return 16'((w & 32'hfff) | ((w >> 4) & 32'hf000));
  endfunction

  function automatic logic [31:0] arm_set16(logic [31:0] w, logic [15:0] v);
    logic [31:0] x;
    x = w & ~32'h000f0fff;
    x[11:0] = v[11:0];
    x[19:16] = v[15:12];
    return x;
  endfunction

  function automatic logic [15:0] thm_imm16(logic [31:0] w);
    logic [15:0] v;
    v[15:12] = w[3:0];
    v[11] = w[10];
    v[10:8] = w[30:28];
    v[7:0] = w[23:16];
    return v;
  endfunction

  function automatic logic [31:0] thm_set16(logic [31:0] w, logic [15:0] v);
    logic [31:0] x;
    x = w & ~32'h70ff040f;
    x[3:0] = v[15:12];
    x[10] = v[11];
    x[30:28] = v[10:8];
    x[23:16] = v[7:0];
    return x;
  endfunction

  function automatic patch_t patch_field(reloc_t q);
    patch_t p;
    logic [31:0] r, f, m;
    logic [2:0] idx;
    int sh;
    p = '{nlo: q.wlo, nhi: q.whi, cnt: CNT_NONE, hiw: 1'b0};
    case (q.kind)
      T_ABS64, T_ABS32, T_ABS24, T_PC32, T_ABS32_NB, T_ARM32: begin
        if (q.addend != 0) r = q.addend;
        else if (q.kind == T_ABS24)
          r = cur_be ? {8'h0, q.wlo[7:0], q.wlo[15:8], q.wlo[23:16]} : {8'h0, q.wlo[23:0]};
        else r = cur_be ? flip_bytes(q.wlo) : q.wlo;
        r += (q.kind == T_PC32 || q.kind == T_ABS32_NB) ? q.srel : q.sabs;
        if (q.kind == T_PC32) r -= q.place + 32'd4;
        if (q.kind == T_ABS24) begin
          p.nlo = cur_be ? {q.wlo[31:24], r[7:0], r[15:8], r[23:16]} : {q.wlo[31:24], r[23:0]};
          p.cnt = CNT_THREE;
        end else begin
          p.nlo = cur_be ? flip_bytes(r) : r;
          p.cnt = CNT_FOUR;
        end
      end
      T_ARM_PC26: begin
        r = {6'd0, q.wlo[23:0], 2'd0};
        r = (r ^ 32'h02000000) - 32'h02000000;
        r = (r + q.addend + q.srel - q.place) >> 2;
        p.nlo = {q.wlo[31:24], r[23:0]};
        p.cnt = CNT_THREE;
      end
      T_ARM_MOV32: begin
        r = {arm_imm16(q.whi), arm_imm16(q.wlo)} + q.addend + q.sabs;
        p.nlo = arm_set16(q.wlo, r[15:0]);
        p.nhi = arm_set16(q.whi, r[31:16]);
        p.cnt = CNT_FOUR;
        p.hiw = 1'b1;
      end
      T_THUMB_MOV32: begin
        r = {thm_imm16(q.whi), thm_imm16(q.wlo)} + q.addend + q.sabs;
        p.nlo = thm_set16(q.wlo, r[15:0]);
        p.nhi = thm_set16(q.whi, r[31:16]);
        p.cnt = CNT_FOUR;
        p.hiw = 1'b1;
      end
      T_THUMB_BR20: begin
        r = {11'd0, q.wlo[10], q.wlo[27], q.wlo[29], q.wlo[5:0], q.wlo[26:16], 1'b0};
        r = (r ^ 32'h00100000) - 32'h00100000;
        r = r + q.addend + q.srel - q.place - 32'd4;
        f = q.wlo;
        f[29] = r[18];
        f[27] = r[19];
        f[26:16] = r[11:1];
        f[10] = r[20];
        f[5:0] = r[17:12];
        p.nlo = f;
        p.cnt = CNT_FOUR;
      end
      T_THUMB_BLX23: begin
        r = {9'd0, q.wlo[10:0], q.wlo[26:16], 1'b0};
        r = (r ^ 32'h00400000) - 32'h00400000;
        r = r + q.addend + q.srel - q.place - 32'd4;
        p.nlo = {q.wlo[31:27], r[11:1], q.wlo[15:11], r[22:12]};
        p.cnt = CNT_FOUR;
      end
      T_ADRP: begin
        r = ((q.sabs + q.addend) & ~32'hfff) - ((cur_base + q.place) & ~32'hfff);
        f = '0;
        f[22:5] = r[31:14];
        f[30:29] = r[13:12];
        p.nlo = merge_field(q.wlo, 32'h60ffffe0, f);
        p.cnt = CNT_FOUR;
      end
      T_ADD_LO12, T_LDST8_LO12, T_LDST16_LO12, T_LDST32_LO12, T_LDST64_LO12,
      T_LDST128_LO12, T_JUMP26, T_CALL26: begin
        idx = 3'(q.kind - T_ADD_LO12);
        r = q.addend + q.sabs;
        case (idx)
          3'd0, 3'd1: begin m = 32'h003ffc00; sh = 0; end
          3'd2:       begin m = 32'h001ffc00; sh = 1; end
          3'd3:       begin m = 32'h000ffc00; sh = 2; end
          3'd4:       begin m = 32'h0007fc00; sh = 3; end
          3'd5:       begin m = 32'h0003fc00; sh = 4; end
          default:    begin m = 32'h03ffffff; sh = 2; end
        endcase
        if (idx >= 3'd6) r = (r - (cur_base + q.place)) >> sh;
        else r = (r >> sh) << 10;
        p.nlo = merge_field(q.wlo, m, r);
        p.cnt = CNT_FOUR;
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic reloc_t row(logic [4:0] k, logic [31:0] wlo, logic [31:0] whi,
                                 logic [31:0] add, logic [31:0] sabs, logic [31:0] srel,
                                 logic [31:0] place);
    return '{kind: k, wlo: wlo, whi: whi, addend: add, sabs: sabs, srel: srel, place: place};
  endfunction

  function automatic reloc_t rand_reloc();
    reloc_t q;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) q.kind = T_NONE;
    else if (pick < 7) q.kind = 5'($urandom_range(T_UNKNOWN_LOW, T_UNKNOWN_TOP));
    else q.kind = 5'($urandom_range(T_ABS64, T_CALL26));
    q.wlo = $urandom;
    q.whi = $urandom;
    pick = $urandom_range(99);
    if (pick < 30) q.addend = '0;
    else if (pick < 55) q.addend = 32'($urandom_range(0, 4095)) - 32'd2048;
    else q.addend = $urandom;
    q.sabs = $urandom;
    q.srel = $urandom;
    pick = $urandom_range(99);
    if (pick < 40) q.place = q.srel + 32'($urandom_range(0, 65535)) - 32'd32768;
    else if (pick < 60) q.place = q.sabs - cur_base + 32'($urandom_range(0, 8191));
    else q.place = $urandom;
    return q;
  endfunction

  task automatic send_reloc(input reloc_t q, input bit known, input patch_t want);
    s_tvalid <= 1'b1;
    s_tuser <= q.kind;
    s_tdata <= {q.place, q.srel, q.sabs, q.addend, q.whi, q.wlo};
    typed_known <= known;
    typed_want <= want;
    do @(posedge clk); while (!s_tready);
    relocs_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (patches_checked < relocs_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [31:0] base, input logic be);
    write_reg(CFG_IMAGE_BASE, base);
    write_reg(CFG_MSB_FIRST, {31'd0, be});
    cfg_valid <= 1'b0;
  endtask

  task automatic load_directed();
    logic [31:0] ones;
    ones = '1;
    directed.push_back('{row(T_NONE, 0, 0, 0, 0, 0, 0), 1'b1,
                         patch_t'{32'h0, 32'h0, CNT_NONE, 1'b0}});
    directed.push_back('{row(T_NONE, ones, ones, ones, ones, ones, ones), 1'b1,
                         patch_t'{ones, ones, CNT_NONE, 1'b0}});
    directed.push_back('{row(T_UNKNOWN_TOP, 32'h12345678, 32'h9abcdef0, ones, ones, ones, ones),
                         1'b1, patch_t'{32'h12345678, 32'h9abcdef0, CNT_NONE, 1'b0}});
    directed.push_back('{row(T_UNKNOWN_LOW, 32'hcafef00d, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4),
                         1'b1, patch_t'{32'hcafef00d, 32'h0, CNT_NONE, 1'b0}});
    directed.push_back('{row(T_ABS32, 32'h12345678, 32'h9abcdef0, 32'h100, 32'h20, ones, 0),
                         1'b1, patch_t'{32'h120, 32'h9abcdef0, CNT_FOUR, 1'b0}});
    directed.push_back('{row(T_ABS32, 0, 0, ones, 32'h1, 0, 0), 1'b1,
                         patch_t'{32'h0, 32'h0, CNT_FOUR, 1'b0}});
    directed.push_back('{row(T_ABS64, 32'h10, 0, 0, 32'h5, 0, 0), 1'b1,
                         patch_t'{32'h15, 32'h0, CNT_FOUR, 1'b0}});
    directed.push_back('{row(T_ABS24, 32'haaffffff, 0, 0, 32'h1, 0, 0), 1'b1,
                         patch_t'{32'haa000000, 32'h0, CNT_THREE, 1'b0}});
    directed.push_back('{row(T_PC32, 0, 0, 0, 0, 32'h1000, 32'hffc), 1'b1,
                         patch_t'{32'h0, 32'h0, CNT_FOUR, 1'b0}});
    directed.push_back('{row(T_ABS32_NB, 0, 0, 32'h5, ones, 32'h7, 0), 1'b1,
                         patch_t'{32'hc, 32'h0, CNT_FOUR, 1'b0}});
    directed.push_back('{row(T_ARM32, ones, 0, 0, 32'h1, 0, 0), 1'b1,
                         patch_t'{32'h0, 32'h0, CNT_FOUR, 1'b0}});
    directed.push_back('{row(T_ARM_PC26, 32'h00800000, 0, 32'h100, 0, 32'h2000, 32'h1000),
                         1'b0, '0});
    directed.push_back('{row(T_ARM_MOV32, ones, ones, 32'h1, 0, 0, 0), 1'b0, '0});
    directed.push_back('{row(T_THUMB_MOV32, 32'hf2400000, 32'hf2c00000, 0, 32'h89abcdef, 0, 0),
                         1'b0, '0});
    directed.push_back('{row(T_THUMB_BR20, ones, ones, 0, 0, 0, 0), 1'b0, '0});
    directed.push_back('{row(T_THUMB_BLX23, 32'hf000e800, 0, 0, 0, 32'h400000, 0), 1'b0, '0});
    directed.push_back('{row(T_ADRP, 32'h90000000, 0, 0, 32'hfffff123, 0, 0), 1'b0, '0});
    directed.push_back('{row(T_ADRP, ones, 0, ones, ones, 0, ones), 1'b0, '0});
    for (int k = T_ADD_LO12; k <= T_CALL26; k++)
      directed.push_back('{row(5'(k), 32'hf9400000, 0, 32'h18, 32'h12345678, 0, 32'h1000),
                           1'b0, '0});
  endtask

  // stimulus
  initial begin
    logic [31:0] bases[NPHASE];
    int tx_pct[NPHASE];
    int rx_pct[NPHASE];
    bases = '{32'h0, 32'hffffffff, $urandom, $urandom, 32'h00001000, $urandom};
    tx_pct = '{0, 62, 0, 27, 0, 0};
    rx_pct = '{0, 0, 62, 27, 0, 62};
    load_directed();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < NPHASE; ph++) begin
      wait_drained();
      set_config(bases[ph], ph[0]);
      tx_idle_pct = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      if (ph == 0)
        foreach (directed[i]) send_reloc(directed[i].q, directed[i].known, directed[i].want);
      if (ph == 2 || ph == 4) hold_asks++;
      repeat (155) send_reloc(rand_reloc(), 1'b0, '0);
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_patches.size() != 0) begin
      $error("%0d expected patches never arrived", expected_patches.size());
      n_err++;
    end
    if (n_err == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done < hold_asks) begin
        hold_left = LONG_HOLD;
        hold_done++;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    reloc_t q;
    patch_t want, got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_BASE) cur_base = cfg_data;
        else cur_be = cfg_data[0];
      end
      if (s_tvalid && s_tready) begin
        q = '{kind: s_tuser, wlo: s_tdata[31:0], whi: s_tdata[63:32], addend: s_tdata[95:64],
              sabs: s_tdata[127:96], srel: s_tdata[159:128], place: s_tdata[191:160]};
        expected_patches.push_back(typed_known ? typed_want : patch_field(q));
      end
      if (m_tvalid && m_tready) begin
        got = '{nlo: m_tdata[31:0], nhi: m_tdata[63:32], cnt: m_tdata[66:64], hiw: m_tdata[67]};
        if (expected_patches.size() == 0) begin
          $error("output beat with no expected patch: %h", m_tdata);
          n_err++;
        end else begin
          want = expected_patches.pop_front();
          if (got.nlo !== want.nlo) begin
            $error("new_word_lo: expected %h, got %h", want.nlo, got.nlo);
            n_err++;
          end
          if (got.nhi !== want.nhi) begin
            $error("new_word_hi: expected %h, got %h", want.nhi, got.nhi);
            n_err++;
          end
          if (got.cnt !== want.cnt) begin
            $error("lo_byte_count: expected %0d, got %0d", want.cnt, got.cnt);
            n_err++;
          end
          if (got.hiw !== want.hiw) begin
            $error("hi_written: expected %0d, got %0d", want.hiw, got.hiw);
            n_err++;
          end
        end
        patches_checked++;
      end
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
